// File: src/shd_pkg.sv
package shd_pkg;

    // Sizes of the pattern store and the symbol alphabet
    localparam int MAX_PATTERN = 64;
    localparam int SYMBOL_BITS = 32;
    localparam int IDX_BITS    = $clog2(MAX_PATTERN);
    localparam int CNT_BITS    = $clog2(MAX_PATTERN + 1);
    localparam int LEN_BITS    = 7;
    localparam int POS_BITS    = 32;

    // Configuration port
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;
    localparam logic REG_PATTERN_LENGTH = 1'b0;
    localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(1);

    // Command codes
    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

    // Window control from the register block
    typedef struct packed {
        logic                restart;
        logic [IDX_BITS-1:0] len_m1;
    } t_cfg;

    // Per-cycle control broadcast to every cell
    typedef struct packed {
        logic shift;
        logic fresh;
        logic clear;
    } t_cell_ctl;

endpackage

// File: src/shd_cell.sv
module shd_cell import shd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic                   i_load,
    input  logic [SYMBOL_BITS-1:0] i_symbol,
    input  logic [CNT_BITS-1:0]    i_cnt,
    output logic [CNT_BITS-1:0]    o_cnt
);

    logic [SYMBOL_BITS-1:0] r_pat;
    logic [CNT_BITS-1:0]    r_cnt;
    logic [CNT_BITS-1:0]    n_cnt;
    logic [CNT_BITS-1:0]    w_base;
    logic                   w_miss;

    // Pattern symbol held by this cell, no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pat <= i_symbol;
        end
    end

    // Running mismatch count taken from the left neighbor, or from zero on a fresh text
    assign w_miss = (i_symbol != r_pat);
    assign w_base = i_ctl.fresh ? '0 : i_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_ctl.clear) begin
            n_cnt = '0;
        end else if (i_ctl.shift) begin
            n_cnt = w_base + CNT_BITS'(w_miss);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

endmodule

// File: src/shd_apb.sv
module shd_apb import shd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output t_cfg                 o_cfg
);

    logic [LEN_BITS-1:0] r_len;
    logic [IDX_BITS-1:0] r_len_m1;
    logic [IDX_BITS-1:0] n_len_m1;
    logic [LEN_BITS-1:0] w_wlen;
    logic                w_wr;
    logic                w_hit;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_hit  = (paddr[2] == REG_PATTERN_LENGTH);
    assign w_wlen = pwdata[LEN_BITS-1:0];

    // Clamp the written length to 1..MAX_PATTERN, kept as length minus one
    always_comb begin
        priority if (w_wlen == '0) begin
            n_len_m1 = '0;
        end else if (w_wlen > LEN_BITS'(MAX_PATTERN)) begin
            n_len_m1 = IDX_BITS'(MAX_PATTERN - 1);
        end else begin
            n_len_m1 = IDX_BITS'(w_wlen - LEN_BITS'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_RESET;
            r_len_m1 <= '0;
        end else if (w_wr && w_hit) begin
            r_len    <= w_wlen;
            r_len_m1 <= n_len_m1;
        end
    end

    assign prdata         = w_hit ? DATA_BITS'(r_len) : '0;
    assign o_cfg.restart  = w_wr && w_hit;
    assign o_cfg.len_m1   = r_len_m1;

endmodule

// File: src/sliding_hamming_distance.sv
// A text transfer reaches the outputs through the cell chain update, then the
// output register.
// Throughput: 1 item per cycle unless o_in_stall; all cells update together.
// Reset (synchronous, active low) clears the counts, window state, output valid
// and sets pattern_length to 1; the pattern store holds until written.
module sliding_hamming_distance import shd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_BITS-1:0]   paddr,
    input  logic [DATA_BITS-1:0]   pwdata,
    output logic [DATA_BITS-1:0]   prdata,
    output logic                   pready,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_command,
    input  logic [SYMBOL_BITS-1:0] i_symbol,
    input  logic [IDX_BITS-1:0]    i_pattern_index,
    input  logic                   i_new_text,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [CNT_BITS-1:0]    o_distance,
    output logic [POS_BITS-1:0]    o_alignment
);

    t_cfg                w_cfg;
    t_cell_ctl           w_ctl;
    logic [CNT_BITS-1:0] w_cnt [MAX_PATTERN];

    logic                r_p1_valid;
    logic [POS_BITS-1:0] r_p1_align;
    logic [LEN_BITS-1:0] r_seen;
    logic [POS_BITS-1:0] r_start;
    logic                r_out_valid;
    logic [CNT_BITS-1:0] r_out_dist;
    logic [POS_BITS-1:0] r_out_align;

    logic                w_accept;
    logic                w_adv;
    logic                w_text;
    logic                w_pat;
    logic                w_restart;
    logic [LEN_BITS-1:0] w_seen_base;
    logic [LEN_BITS-1:0] w_seen_inc;
    logic [POS_BITS-1:0] w_start_base;
    logic                w_res;

    shd_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Handshake: the result stage moves when the output register is free
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_p1_valid && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_text     = w_accept && (i_command == CMD_TEXT);
    assign w_pat      = w_accept && (i_command == CMD_PATTERN);
    assign w_restart  = w_pat || w_cfg.restart;

    assign w_ctl.shift = w_text;
    assign w_ctl.fresh = i_new_text;
    assign w_ctl.clear = w_restart;

    // Chain of cells, counts flow from cell k-1 to cell k
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        logic [CNT_BITS-1:0] w_left;
        if (k == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_body
            assign w_left = w_cnt[k-1];
        end
        shd_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_load   (w_pat && (i_pattern_index == IDX_BITS'(k))),
            .i_symbol (i_symbol),
            .i_cnt    (w_left),
            .o_cnt    (w_cnt[k])
        );
    end

    // Window bookkeeping
    assign w_seen_base  = i_new_text ? '0 : r_seen;
    assign w_seen_inc   = (w_seen_base < LEN_BITS'(MAX_PATTERN)) ?
                          w_seen_base + LEN_BITS'(1) : w_seen_base;
    assign w_start_base = i_new_text ? '0 : r_start;
    assign w_res        = w_seen_inc > LEN_BITS'(w_cfg.len_m1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_start    <= '0;
            r_p1_valid <= 1'b0;
        end else begin
            if (w_restart) begin
                r_seen  <= '0;
                r_start <= '0;
            end else if (w_text) begin
                r_seen <= w_seen_inc;
                if (w_res) begin
                    r_start <= w_start_base + POS_BITS'(1);
                end else begin
                    r_start <= w_start_base;
                end
            end
            if (w_accept || w_adv) begin
                r_p1_valid <= w_text && w_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_text) begin
            r_p1_align <= w_start_base;
        end
    end

    // Output register: picks the count of the last active cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_dist  <= w_cnt[w_cfg.len_m1];
            r_out_align <= r_p1_align;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_distance  = r_out_dist;
    assign o_alignment = r_out_align;

endmodule

// File: src/shd_checker.sv
module shd_checker import shd_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [CNT_BITS-1:0] o_distance,
    input logic [POS_BITS-1:0] o_alignment
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_distance) && $stable(o_alignment))
        else $error("stalled result changed");

    // Input backpressure only comes from a blocked output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output free");

    // Distance never exceeds the pattern store depth
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_distance <= CNT_BITS'(MAX_PATTERN))
        else $error("distance out of range");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind sliding_hamming_distance shd_checker u_shd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_distance  (o_distance),
    .o_alignment (o_alignment)
);
